FILE: sv/ssrm_pkg.sv
// Shared types and constants for the sensor SPI register master.
`default_nettype none

package ssrm_pkg;

	localparam int ADDR_BITS   = 9;
	localparam int DATA_BITS   = 16;
	localparam int HALF_W      = 8;
	localparam logic [HALF_W-1:0] HALF_RESET = 8'd10;

	// bit counter spans the longer of the two shifted fields
	localparam int CNT_W = $clog2((DATA_BITS > ADDR_BITS) ? DATA_BITS : ADDR_BITS);

	localparam int IN_FIELDS_W  = 2 + ADDR_BITS + DATA_BITS + 1;
	localparam int IN_W         = ((IN_FIELDS_W + 7) / 8) * 8;
	localparam int OUT_FIELDS_W = DATA_BITS + 5;
	localparam int OUT_W        = ((OUT_FIELDS_W + 7) / 8) * 8;

	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	// raw action codes on the input stream
	localparam logic [1:0] ACT_WRITE = 2'd1;
	localparam logic [1:0] ACT_READ  = 2'd2;

	typedef enum logic [1:0] {
		CMD_TICK,
		CMD_WRITE,
		CMD_READ
	} cmd_t;

	typedef enum logic [3:0] {
		PH_IDLE,
		PH_SEL_HIGH,
		PH_SEL_LOW,
		PH_ADDR_LO,
		PH_ADDR_HI,
		PH_CMD_LO,
		PH_CMD_HI,
		PH_TURN_LO,
		PH_TURN_HI,
		PH_DATA_LO,
		PH_DATA_HI,
		PH_END
	} phase_t;

	// input beat layout, lowest field in the lowest bits
	typedef struct packed {
		logic [IN_W-IN_FIELDS_W-1:0] pad;
		logic                        miso;
		logic [DATA_BITS-1:0]        write_data;
		logic [ADDR_BITS-1:0]        address;
		logic [1:0]                  action;
	} in_beat_t;

	// result beat layout, lowest field in the lowest bits
	typedef struct packed {
		logic [OUT_W-OUT_FIELDS_W-1:0] pad;
		logic                          done_res;
		logic [DATA_BITS-1:0]          read_data;
		logic                          busy_res;
		logic                          mosi;
		logic                          sclk;
		logic                          select_n;
	} out_beat_t;

	// classified item handed from front to back
	typedef struct packed {
		cmd_t                 cmd;
		logic [ADDR_BITS-1:0] address;
		logic [DATA_BITS-1:0] write_data;
		logic                 miso;
	} item_t;

endpackage

`default_nettype wire

FILE: sv/ssrm_front.sv
// Front end: unpacks input beats and classifies the action code.
`default_nettype none

module ssrm_front import ssrm_pkg::*; (
	input  wire logic            s_tvalid,
	output logic                 s_tready,
	input  wire logic [IN_W-1:0] s_tdata,
	input  wire logic            q_full,
	output logic                 q_push,
	output item_t                q_item
);

	in_beat_t beat;

	assign beat     = in_beat_t'(s_tdata);
	assign s_tready = !q_full;
	assign q_push   = s_tvalid && !q_full;

	always_comb begin
		q_item.address    = beat.address;
		q_item.write_data = beat.write_data;
		q_item.miso       = beat.miso;
		case (beat.action)
			ACT_WRITE: q_item.cmd = CMD_WRITE;
			ACT_READ:  q_item.cmd = CMD_READ;
			default:   q_item.cmd = CMD_TICK;
		endcase
	end

endmodule

`default_nettype wire

FILE: sv/ssrm_queue.sv
// Short queue of classified items between front and back.
`default_nettype none

module ssrm_queue import ssrm_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  push,
	input  wire item_t push_item,
	output logic       full,
	input  wire logic  pop,
	output logic       valid,
	output item_t      head
);

	item_t             mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	assign full  = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign valid = (count_q != '0);
	assign head  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

FILE: sv/ssrm_back.sv
// Back end: SPI phase sequencer, shift registers and result register.
`default_nettype none

module ssrm_back import ssrm_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              cfg_we,
	input  wire logic [HALF_W-1:0] cfg_wdata,
	input  wire logic              q_valid,
	input  wire item_t             q_item,
	output logic                   q_pop,
	output logic                   m_tvalid,
	input  wire logic              m_tready,
	output logic [OUT_W-1:0]       m_tdata
);

	logic [HALF_W-1:0]    half_q;
	phase_t               phase_q, phase_d;
	logic [CNT_W-1:0]     bit_q, bit_d;
	logic [HALF_W-1:0]    tick_q, tick_d;
	logic [DATA_BITS-1:0] tx_q, tx_d;
	logic [ADDR_BITS-1:0] addr_q, addr_d;
	logic [DATA_BITS-1:0] rx_q, rx_d;
	logic                 is_read_q, is_read_d;
	logic                 sel_q, sel_d;
	logic                 clk_q, clk_d;
	logic                 mosi_q, mosi_d;

	logic                 out_valid_q;
	logic [OUT_W-1:0]     out_data_q;

	logic                 fire;
	logic [HALF_W-1:0]    limit;
	logic                 start;
	logic                 expired;
	logic                 enter;
	logic                 done;
	logic                 more_addr;
	logic                 more_data;
	out_beat_t            res;

	assign fire      = q_valid && (!out_valid_q || m_tready);
	assign q_pop     = fire;
	assign limit     = (half_q == '0) ? HALF_W'(1) : half_q;
	assign start     = (phase_q == PH_IDLE) &&
	                   (q_item.cmd == CMD_WRITE || q_item.cmd == CMD_READ);
	assign expired   = (phase_q != PH_IDLE) && (tick_q >= limit);
	assign more_addr = bit_q < CNT_W'(ADDR_BITS - 1);
	assign more_data = bit_q < CNT_W'(DATA_BITS - 1);

	// next phase
	always_comb begin
		phase_d = phase_q;
		enter   = 1'b0;
		done    = 1'b0;
		if (fire) begin
			if (phase_q == PH_IDLE) begin
				if (start) begin
					phase_d = PH_SEL_HIGH;
					enter   = 1'b1;
				end
			end else if (expired) begin
				enter = 1'b1;
				case (phase_q)
					PH_SEL_HIGH: phase_d = PH_SEL_LOW;
					PH_SEL_LOW:  phase_d = PH_ADDR_LO;
					PH_ADDR_LO:  phase_d = PH_ADDR_HI;
					PH_ADDR_HI:  phase_d = more_addr ? PH_ADDR_LO : PH_CMD_LO;
					PH_CMD_LO:   phase_d = PH_CMD_HI;
					PH_CMD_HI:   phase_d = is_read_q ? PH_TURN_LO : PH_DATA_LO;
					PH_TURN_LO:  phase_d = PH_TURN_HI;
					PH_TURN_HI:  phase_d = PH_DATA_LO;
					PH_DATA_LO:  phase_d = PH_DATA_HI;
					PH_DATA_HI:  phase_d = more_data ? PH_DATA_LO : PH_END;
					default: begin
						phase_d = PH_IDLE;
						done    = 1'b1;
					end
				endcase
			end
		end
	end

	// datapath and pin levels
	always_comb begin
		bit_d     = bit_q;
		tick_d    = tick_q;
		tx_d      = tx_q;
		addr_d    = addr_q;
		rx_d      = rx_q;
		is_read_d = is_read_q;
		sel_d     = sel_q;
		clk_d     = clk_q;
		mosi_d    = mosi_q;
		if (fire) begin
			if (phase_q == PH_IDLE) begin
				if (start) begin
					is_read_d = (q_item.cmd == CMD_READ);
					addr_d    = q_item.address;
					tx_d      = q_item.write_data;
					rx_d      = '0;
					bit_d     = '0;
				end
			end else if (expired) begin
				case (phase_q)
					PH_SEL_LOW, PH_CMD_HI, PH_TURN_HI: begin
						bit_d = '0;
					end
					PH_ADDR_HI: begin
						addr_d = {addr_q[ADDR_BITS-2:0], 1'b0};
						if (more_addr) begin
							bit_d = bit_q + 1'b1;
						end
					end
					PH_DATA_HI: begin
						tx_d = {tx_q[DATA_BITS-2:0], 1'b0};
						if (more_data) begin
							bit_d = bit_q + 1'b1;
						end
					end
					default: ;
				endcase
			end else begin
				tick_d = tick_q + 1'b1;
			end

			if (enter) begin
				tick_d = HALF_W'(1);
				case (phase_d)
					PH_SEL_HIGH: begin
						sel_d = 1'b1;
						clk_d = 1'b0;
					end
					PH_SEL_LOW: sel_d = 1'b0;
					PH_ADDR_LO: begin
						clk_d  = 1'b0;
						mosi_d = addr_d[ADDR_BITS-1];
					end
					PH_CMD_LO: begin
						clk_d  = 1'b0;
						mosi_d = !is_read_d;
					end
					PH_TURN_LO, PH_END: clk_d = 1'b0;
					PH_DATA_LO: begin
						clk_d = 1'b0;
						if (is_read_d) begin
							rx_d = {rx_q[DATA_BITS-2:0], q_item.miso};
						end else begin
							mosi_d = tx_d[DATA_BITS-1];
						end
					end
					PH_IDLE: begin
						sel_d  = 1'b1;
						clk_d  = 1'b0;
						tick_d = '0;
					end
					PH_ADDR_HI, PH_CMD_HI, PH_TURN_HI, PH_DATA_HI: clk_d = 1'b1;
					default: ;
				endcase
			end
		end
	end

	always_comb begin
		res           = '0;
		res.select_n  = sel_d;
		res.sclk      = clk_d;
		res.mosi      = mosi_d;
		res.busy_res  = (phase_d != PH_IDLE);
		res.read_data = (done && is_read_q) ? rx_q : '0;
		res.done_res  = done;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			half_q      <= HALF_RESET;
			phase_q     <= PH_IDLE;
			bit_q       <= '0;
			tick_q      <= '0;
			tx_q        <= '0;
			addr_q      <= '0;
			rx_q        <= '0;
			is_read_q   <= 1'b0;
			sel_q       <= 1'b1;
			clk_q       <= 1'b0;
			mosi_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				half_q <= cfg_wdata;
			end
			phase_q   <= phase_d;
			bit_q     <= bit_d;
			tick_q    <= tick_d;
			tx_q      <= tx_d;
			addr_q    <= addr_d;
			rx_q      <= rx_d;
			is_read_q <= is_read_d;
			sel_q     <= sel_d;
			clk_q     <= clk_d;
			mosi_q    <= mosi_d;
			if (fire) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			out_data_q <= OUT_W'(res);
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

	a_idle_pins: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_IDLE) |-> (sel_q && !clk_q))
		else $error("pins not parked while idle");

	a_clk_high_phase: assert property (@(posedge clk) disable iff (!arst_n)
		clk_q |-> (phase_q == PH_ADDR_HI || phase_q == PH_CMD_HI ||
		           phase_q == PH_TURN_HI || phase_q == PH_DATA_HI))
		else $error("sclk high outside a high phase");

	a_tick_live: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q != PH_IDLE) |-> (tick_q != '0))
		else $error("tick counter zero inside a frame");

	a_start_frame: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && start) |=> (phase_q == PH_SEL_HIGH && sel_q))
		else $error("accepted start did not open a frame");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && done) |=> (phase_q == PH_IDLE && out_valid_q))
		else $error("frame end did not return to idle with a result");

endmodule

`default_nettype wire

FILE: sv/sensor_spi_register_master_unit.sv
// Top level of the sensor SPI register master: front, queue and back end.
//
//  channel  | direction | handshake          | contents
//  ---------+-----------+--------------------+-----------------------------------------
//  s_*      | in        | s_tvalid/s_tready  | tick with optional write or read start
//  m_*      | out       | m_tvalid/m_tready  | pin levels, busy, read data, done
//  cfg_*    | in        | cfg_we             | half_period_ticks, ticks per SCK phase
//
// One beat per clock sustained while results are taken (m_tready high): each
// tick is one step of the back end's phase sequencer, which resolves the
// whole tick when it pops it. An accepted beat passes through the queue and
// then the result register before it can leave on m_tdata.
// The two-entry queue absorbs input beats while m_tready is low; a held
// result stalls the sequencer first and the front only once the queue fills.
// arst_n returns the link to idle with select high, SCK low, MOSI low and
// half_period_ticks at 10.
`default_nettype none

module sensor_spi_register_master_unit import ssrm_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	// configuration: half_period_ticks
	input  wire logic              cfg_we,
	input  wire logic [HALF_W-1:0] cfg_wdata,
	// tick beats
	input  wire logic              s_tvalid,
	output logic                   s_tready,
	// [1:0] action, [10:2] address, [26:11] write_data, [27] miso, rest zero
	input  wire logic [IN_W-1:0]   s_tdata,
	// result beats
	output logic                   m_tvalid,
	input  wire logic              m_tready,
	// [0] select_n, [1] sclk, [2] mosi, [3] busy_res, [19:4] read_data,
	// [20] done_res, rest zero
	output logic [OUT_W-1:0]       m_tdata
);

	item_t front_item;
	item_t head_item;
	logic  q_push;
	logic  q_full;
	logic  q_valid;
	logic  q_pop;

	// classify the action and push into the queue
	ssrm_front u_front (
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.q_full   (q_full),
		.q_push   (q_push),
		.q_item   (front_item)
	);

	// decouple acceptance from the sequencer's output stalls
	ssrm_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_item (front_item),
		.full      (q_full),
		.pop       (q_pop),
		.valid     (q_valid),
		.head      (head_item)
	);

	// advance the frame one tick per popped item and register the result
	ssrm_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.q_valid   (q_valid),
		.q_item    (head_item),
		.q_pop     (q_pop),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

endmodule

`default_nettype wire
